@@ rtl/crc32wa_pkg.sv @@
// crc32wa_pkg: shared constants for the CRC-32 word absorb/undo unit.
// No dependencies; used by the interfaces and all RTL modules.
`timescale 1ns / 1ps
package crc32wa_pkg;
	localparam int DATA_W = 32;
	localparam int REQ_W  = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_ABSORB = 2'd0;
	localparam logic [REQ_W-1:0] REQ_UNDO   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd2;

	localparam logic [DATA_W-1:0] POLY_RESET = 32'h0FC2_2F87;
endpackage

@@ rtl/crc32wa_if.sv @@
// Valid/ready channel interfaces for the CRC-32 word absorb/undo unit.
// Depends on crc32wa_pkg for field widths.
`timescale 1ns / 1ps
interface crc32wa_req_if;
	logic                             valid;
	logic                             ready;
	logic [crc32wa_pkg::REQ_W-1:0]    req_type;
	logic [crc32wa_pkg::DATA_W-1:0]   data_word;
	modport source (output valid, output req_type, output data_word, input ready);
	modport sink   (input valid, input req_type, input data_word, output ready);
endinterface

interface crc32wa_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [crc32wa_pkg::DATA_W-1:0]   crc_value;
	modport source (output valid, output crc_value, input ready);
	modport sink   (input valid, input crc_value, output ready);
endinterface

interface crc32wa_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [crc32wa_pkg::DATA_W-1:0]   polynomial;
	modport source (output valid, output polynomial, input ready);
	modport sink   (input valid, input polynomial, output ready);
endinterface

@@ rtl/crc32wa_cols.sv @@
// crc32wa_cols: holds the polynomial and builds the forward and inverse
// transfer-matrix columns (one lane per bit). Depends on crc32wa_pkg.
`timescale 1ns / 1ps
module crc32wa_cols #(
	parameter int W = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           poly_we,
	input  logic [crc32wa_pkg::DATA_W-1:0] poly_wdata,
	output logic                           cols_ready,
	output logic [W-1:0]                   fwd_col [W],
	output logic [W-1:0]                   inv_col [W]
);
	localparam int XW    = W + crc32wa_pkg::DATA_W;
	localparam int CNT_W = $clog2(W);
	localparam logic [XW-1:0] POLY_EXT = XW'(crc32wa_pkg::POLY_RESET);

	typedef enum logic [2:0] {
		ST_INIT  = 3'b001,
		ST_SWEEP = 3'b010,
		ST_RUN   = 3'b100
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [W-1:0]       poly_q;
	logic [W-1:0]       fwd_q [W];
	logic [W-1:0]       inv_q [W];
	logic [XW-1:0]      wdata_ext;

	function automatic logic [W-1:0] fwd_step(logic [W-1:0] r, logic [W-1:0] p);
		logic [W-1:0] sh;
		sh = {r[W-2:0], 1'b0};
		return r[W-1] ? (sh ^ p) : sh;
	endfunction

	// inverse step: fold poly back in on a set LSB, rotate that bit to the top
	function automatic logic [W-1:0] inv_step(logic [W-1:0] r, logic [W-1:0] p);
		logic [W-1:0] x;
		x = r[0] ? (r ^ p) : r;
		return {r[0], x[W-1:1]};
	endfunction

	assign wdata_ext = XW'(poly_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
			poly_q  <= POLY_EXT[W-1:0];
		end else if (poly_we) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
			poly_q  <= wdata_ext[W-1:0];
		end else begin
			case (state_q)
				ST_INIT: begin
					state_q <= ST_SWEEP;
					cnt_q   <= '0;
				end
				ST_SWEEP: begin
					if (cnt_q == CNT_W'(W - 1)) begin
						state_q <= ST_RUN;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	// each lane starts as a unit vector and is stepped W times
	always_ff @(posedge clk) begin
		for (int j = 0; j < W; j++) begin
			if (state_q == ST_INIT) begin
				fwd_q[j] <= W'(1) << j;
				inv_q[j] <= W'(1) << j;
			end else if (state_q == ST_SWEEP) begin
				fwd_q[j] <= fwd_step(fwd_q[j], poly_q);
				inv_q[j] <= inv_step(inv_q[j], poly_q);
			end
		end
	end

	assign cols_ready = (state_q == ST_RUN);
	assign fwd_col    = fwd_q;
	assign inv_col    = inv_q;
endmodule

@@ rtl/crc32_word_absorb_and_undo_unit.sv @@
// Top level of the CRC-32 word absorb/undo unit (MSB-first LFSR).
// Depends on crc32wa_pkg, crc32wa_if.sv and crc32wa_cols.
//
//   port  dir   fields                 purpose
//   req   sink  req_type, data_word    absorb / undo / load one word
//   rsp   src   crc_value              register value after each word
//   cfg   sink  polynomial             feedback polynomial write
//
// One word per cycle unless rsp stalls; input stage, then rsp register.
// The critical path is a W-input XOR tree over the stored matrix columns.
// After reset and after every polynomial write the columns are rebuilt
// with req.ready low. cfg is always ready.
// A stalled rsp holds its word; one more word waits in the input stage.
`timescale 1ns / 1ps
module crc32_word_absorb_and_undo_unit #(
	parameter int WORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	crc32wa_req_if.sink         req,
	crc32wa_rsp_if.source       rsp,
	crc32wa_cfg_if.sink         cfg
);
	localparam int W  = WORD_BITS;
	localparam int XW = W + crc32wa_pkg::DATA_W;

	logic                              cols_ready;
	logic [W-1:0]                      fwd_col [W];
	logic [W-1:0]                      inv_col [W];

	logic                              valid_s1;
	logic [crc32wa_pkg::REQ_W-1:0]     req_s1;
	logic [W-1:0]                      word_s1;
	logic [W-1:0]                      crc_q;
	logic                              rsp_valid_q;
	logic [crc32wa_pkg::DATA_W-1:0]    rsp_data_q;

	logic                              advance;
	logic [XW-1:0]                     din_ext;
	logic [XW-1:0]                     crc_ext;
	logic [W-1:0]                      fwd_in;
	logic [W-1:0]                      fwd_res;
	logic [W-1:0]                      inv_res;
	logic [W-1:0]                      crc_next;

	crc32wa_cols #(.W(W)) u_cols (
		.clk        (clk),
		.arst_n     (arst_n),
		.poly_we    (cfg.valid),
		.poly_wdata (cfg.polynomial),
		.cols_ready (cols_ready),
		.fwd_col    (fwd_col),
		.inv_col    (inv_col)
	);

	assign cfg.ready = 1'b1;
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = cols_ready && (!valid_s1 || advance);
	assign din_ext   = XW'(req.data_word);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1  <= req.req_type;
			word_s1 <= din_ext[W-1:0];
		end
	end

	// both directions are linear in the register: matrix-vector over GF(2)
	assign fwd_in = crc_q ^ word_s1;

	always_comb begin
		fwd_res = '0;
		inv_res = '0;
		for (int j = 0; j < W; j++) begin
			fwd_res = fwd_res ^ (fwd_col[j] & {W{fwd_in[j]}});
			inv_res = inv_res ^ (inv_col[j] & {W{crc_q[j]}});
		end
		inv_res = inv_res ^ word_s1;
	end

	always_comb begin
		case (req_s1)
			crc32wa_pkg::REQ_ABSORB: crc_next = fwd_res;
			crc32wa_pkg::REQ_UNDO:   crc_next = inv_res;
			crc32wa_pkg::REQ_LOAD:   crc_next = word_s1;
			default:                 crc_next = crc_q;
		endcase
	end

	assign crc_ext = XW'(crc_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				crc_q       <= crc_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_data_q <= crc_ext[crc32wa_pkg::DATA_W-1:0];
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.crc_value = rsp_data_q;

	// a polynomial write always invalidates the columns
	a_cfg_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid |=> !cols_ready)
		else $error("columns still marked ready after polynomial write");

	// input stage holds its word while the result register is stalled
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp_valid_q && !rsp.ready |=> valid_s1 && $stable(word_s1))
		else $error("input stage lost a word under output stall");

	// register only moves when a word is retired
	a_crc_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(crc_q))
		else $error("crc register changed without a word");

	// load puts the word into the register and raises a result
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1 == crc32wa_pkg::REQ_LOAD |=>
			rsp_valid_q && crc_q == $past(word_s1))
		else $error("load did not set the register");
endmodule

@@ dv/tb.sv @@
// tb: self-checking bench for crc32_word_absorb_and_undo_unit.
// Needs crc32wa_pkg and the channel interfaces in crc32wa_if.sv. It predicts each
// crc_value from its own copy of the register and polynomial, and checks every word in order.
`timescale 1ns / 1ps
module tb;
	localparam logic [crc32wa_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [crc32wa_pkg::REQ_W-1:0]  op;
		logic [crc32wa_pkg::DATA_W-1:0] word;
	} crc_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	crc32wa_req_if req_if();
	crc32wa_rsp_if rsp_if();
	crc32wa_cfg_if cfg_if();

	logic                           req_valid_q = 1'b0;
	logic [crc32wa_pkg::REQ_W-1:0]  req_type_q = crc32wa_pkg::REQ_ABSORB;
	logic [crc32wa_pkg::DATA_W-1:0] req_word_q = '0;
	logic                           rsp_ready_q = 1'b0;
	logic                           cfg_valid_q = 1'b0;
	logic [crc32wa_pkg::DATA_W-1:0] cfg_poly_q = crc32wa_pkg::POLY_RESET;

	assign req_if.valid     = req_valid_q;
	assign req_if.req_type  = req_type_q;
	assign req_if.data_word = req_word_q;
	assign rsp_if.ready     = rsp_ready_q;
	assign cfg_if.valid     = cfg_valid_q;
	assign cfg_if.polynomial = cfg_poly_q;

	crc32_word_absorb_and_undo_unit #(
		.WORD_BITS(crc32wa_pkg::DATA_W)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// predictor state
	logic [crc32wa_pkg::DATA_W-1:0] crc_state = '0;
	logic [crc32wa_pkg::DATA_W-1:0] poly_model = crc32wa_pkg::POLY_RESET;

	crc_word_t                      word_queue[$];
	logic [crc32wa_pkg::DATA_W-1:0] crc_expected[$];

	int burst_left = 0;
	int gap_left = 0;
	int stall_tick = 0;
	int cycle_count = 0;
	int errors = 0;

	logic [crc32wa_pkg::DATA_W-1:0] crc_oldest;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [crc32wa_pkg::DATA_W-1:0] crc_absorb(
			input logic [crc32wa_pkg::DATA_W-1:0] r,
			input logic [crc32wa_pkg::DATA_W-1:0] w,
			input logic [crc32wa_pkg::DATA_W-1:0] p);
		logic msb;
		r = r ^ w;
		for (int i = 0; i < crc32wa_pkg::DATA_W; i++) begin
			msb = r[crc32wa_pkg::DATA_W-1];
			r = r << 1;
			if (msb)
				r = r ^ p;
		end
		return r;
	endfunction

	// inverse step: fold poly back in on a set LSB, then rotate that LSB into the MSB
	function automatic logic [crc32wa_pkg::DATA_W-1:0] crc_undo(
			input logic [crc32wa_pkg::DATA_W-1:0] r,
			input logic [crc32wa_pkg::DATA_W-1:0] w,
			input logic [crc32wa_pkg::DATA_W-1:0] p);
		logic lsb;
		for (int i = 0; i < crc32wa_pkg::DATA_W; i++) begin
			lsb = r[0];
			if (lsb)
				r = r ^ p;
			r = {lsb, r[crc32wa_pkg::DATA_W-1:1]};
		end
		return r ^ w;
	endfunction

	function automatic logic [crc32wa_pkg::DATA_W-1:0] crc_next(input crc_word_t item,
			input logic [crc32wa_pkg::DATA_W-1:0] r,
			input logic [crc32wa_pkg::DATA_W-1:0] p);
		case (item.op)
			crc32wa_pkg::REQ_ABSORB: return crc_absorb(r, item.word, p);
			crc32wa_pkg::REQ_UNDO:   return crc_undo(r, item.word, p);
			crc32wa_pkg::REQ_LOAD:   return item.word;
			default:                 return r;
		endcase
	endfunction

	function automatic logic [crc32wa_pkg::DATA_W-1:0] any_word();
		logic [crc32wa_pkg::DATA_W-1:0] one_hot;
		one_hot = crc32wa_pkg::DATA_W'(1) << $urandom_range(0, crc32wa_pkg::DATA_W - 1);
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return one_hot;
			3:       return ~one_hot;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_word(input logic [crc32wa_pkg::REQ_W-1:0] op,
			input logic [crc32wa_pkg::DATA_W-1:0] word);
		crc_word_t item;
		item.op = op;
		item.word = word;
		word_queue.push_back(item);
	endtask

	// mostly load/absorb runs unwound by undo in reverse order, some loose noise
	task automatic queue_traffic(input int count);
		int added;
		int n_abs;
		int n_undo;
		logic [crc32wa_pkg::DATA_W-1:0] absorbed[$];
		added = 0;
		while (added < count) begin
			if ($urandom_range(0, 9) < 7) begin
				absorbed.delete();
				if ($urandom_range(0, 1)) begin
					queue_word(crc32wa_pkg::REQ_LOAD, any_word());
					added++;
				end
				n_abs = $urandom_range(1, 6);
				repeat (n_abs) begin
					absorbed.push_back(any_word());
					queue_word(crc32wa_pkg::REQ_ABSORB, absorbed[$]);
				end
				n_undo = $urandom_range(0, n_abs);
				repeat (n_undo)
					queue_word(crc32wa_pkg::REQ_UNDO, absorbed.pop_back());
				added += n_abs + n_undo;
			end else begin
				queue_word(crc32wa_pkg::REQ_W'($urandom_range(crc32wa_pkg::REQ_ABSORB,
					REQ_UNUSED)), any_word());
				added++;
			end
		end
	endtask

	task automatic wait_idle();
		while (word_queue.size() != 0 || crc_expected.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_poly(input logic [crc32wa_pkg::DATA_W-1:0] p);
		wait_idle();
		@(posedge clk);
		cfg_valid_q <= 1'b1;
		cfg_poly_q <= p;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_valid_q <= 1'b0;
		poly_model = p;
		@(negedge clk);
	endtask

	// driver: bursts of random length separated by random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid_q && req_if.ready) begin
				crc_state = crc_next(word_queue[0], crc_state, poly_model);
				crc_expected.push_back(crc_state);
				word_queue.delete(0);
			end
			if (req_valid_q && !req_if.ready) begin
				// hold the offered word
			end else if (gap_left > 0) begin
				gap_left--;
				req_valid_q <= 1'b0;
			end else if (word_queue.size() > 0) begin
				req_valid_q <= 1'b1;
				req_type_q <= word_queue[0].op;
				req_word_q <= word_queue[0].word;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
					if ($urandom_range(0, 19) == 0)
						gap_left = 25;
				end
			end else begin
				req_valid_q <= 1'b0;
			end
		end
	end

	// monitor: in-order check, ready cycles through several stall patterns
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_ready_q) begin
				if (crc_expected.size() == 0) begin
					$display("%0t: unexpected crc_value, expected none, actual %08h",
						$time, rsp_if.crc_value);
					errors++;
				end else begin
					crc_oldest = crc_expected.pop_front();
					if (rsp_if.crc_value !== crc_oldest) begin
						$display("%0t: crc_value mismatch, expected %08h, actual %08h",
							$time, crc_oldest, rsp_if.crc_value);
						errors++;
					end
				end
			end
			stall_tick++;
			case ((stall_tick / 128) % 4)
				0:       rsp_ready_q <= 1'b1;
				1:       rsp_ready_q <= (stall_tick % 3) != 0;
				2:       rsp_ready_q <= 1'($urandom_range(0, 1));
				default: rsp_ready_q <= $urandom_range(0, 7) == 0;
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d words unsent, %0d results outstanding",
				$time, word_queue.size(), crc_expected.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset polynomial, edge words and every request code
		queue_word(crc32wa_pkg::REQ_LOAD, '0);
		queue_word(crc32wa_pkg::REQ_ABSORB, '0);
		queue_word(crc32wa_pkg::REQ_ABSORB, '1);
		queue_word(crc32wa_pkg::REQ_UNDO, '1);
		queue_word(crc32wa_pkg::REQ_UNDO, '0);
		queue_word(crc32wa_pkg::REQ_LOAD, '1);
		queue_word(crc32wa_pkg::REQ_ABSORB, 32'h8000_0000);
		queue_word(crc32wa_pkg::REQ_UNDO, 32'h8000_0000);
		queue_word(REQ_UNUSED, '1);
		queue_word(REQ_UNUSED, '0);
		queue_word(crc32wa_pkg::REQ_LOAD, 32'h1234_5678);
		queue_word(crc32wa_pkg::REQ_ABSORB, 32'hA5A5_A5A5);
		queue_word(crc32wa_pkg::REQ_UNDO, 32'hA5A5_A5A5);
		queue_traffic(60);

		write_poly(32'h04C1_1DB7);
		queue_traffic(80);

		// zero polynomial: plain shift, undo is a pure rotate
		write_poly('0);
		queue_word(crc32wa_pkg::REQ_LOAD, any_word());
		queue_word(crc32wa_pkg::REQ_ABSORB, '1);
		queue_word(crc32wa_pkg::REQ_UNDO, '1);
		queue_traffic(40);

		write_poly('1);
		queue_traffic(60);

		// bit 0 clear: undo does not restore the prior value
		write_poly({31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b0});
		queue_word(crc32wa_pkg::REQ_ABSORB, any_word());
		queue_word(crc32wa_pkg::REQ_UNDO, any_word());
		queue_traffic(30);
		wait_idle();
		queue_traffic(30);

		write_poly($urandom | 32'h1);
		queue_traffic(80);

		write_poly(crc32wa_pkg::POLY_RESET);
		queue_traffic(20);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
